// ===== sv/skv_pkg.sv =====
// ----------------------------------------------------------------------------
// skv_pkg: shared types for the sorted key/value table
// Command codes, cell operations, cell flags and controller states.
// ----------------------------------------------------------------------------
package skv_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [2:0] CMD_LOOKUP      = 3'd0;
    localparam logic [2:0] CMD_MAP         = 3'd1;
    localparam logic [2:0] CMD_UNMAP       = 3'd2;
    localparam logic [2:0] CMD_UNMAP_VALUE = 3'd3;
    localparam logic [2:0] CMD_REMAP       = 3'd4;
    localparam logic [2:0] CMD_CLEAR       = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_COMPARE,
        OP_MARK,
        OP_WRITE,
        OP_INSERT,
        OP_DELETE,
        OP_SWAP
    } skv_op_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic dead;
    } skv_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMP2,
        ST_EVAL2,
        ST_COMPACT,
        ST_DONE
    } skv_state_t;

endpackage

// ===== sv/sorted_key_value_table.sv =====
// Steps, from input transfer: a clear goes straight to the result; lookup, map and
// unmap compare, then evaluate; a remap that changes the key compares and evaluates
// twice; unmap by value marks, then runs odd-even swap rounds of the cell chain until
// sorted (at most TABLE_DEPTH rounds). One item is in work at a time; the next
// transfer is taken the cycle after its result loads the output register.
// Reset clears the entry count, the parity and hit registers, the cell flags and the handshake state only.
// ----------------------------------------------------------------------------
// sorted_key_value_table: sorted key/value map built from a chain of cells
// Each cell compares its key against a broadcast key; inserts and deletes
// shift the chain by one place, value deletes compact it by swap rounds.
// ----------------------------------------------------------------------------
module sorted_key_value_table
    import skv_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            command,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [VALUE_BITS-1:0] value_out,
    output logic [CNT_W-1:0]      position,
    output logic [CNT_W-1:0]      entry_count,
    output logic                  status
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    skv_state_t            state_reg;
    skv_state_t            state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  parity_reg;
    logic                  parity_next;
    logic                  hit_reg;
    logic                  hit_next;

    logic [2:0]            cmd_hold_reg;
    logic [KEY_BITS-1:0]   key_hold_reg;
    logic [KEY_BITS-1:0]   nkey_hold_reg;
    logic [VALUE_BITS-1:0] val_hold_reg;

    logic                  res_found_reg;
    logic                  res_found_next;
    logic [VALUE_BITS-1:0] res_val_reg;
    logic [VALUE_BITS-1:0] res_val_next;
    logic [CNT_W-1:0]      res_pos_reg;
    logic [CNT_W-1:0]      res_pos_next;
    logic                  res_status_reg;
    logic                  res_status_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_found_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [CNT_W-1:0]      out_pos_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_status_reg;
    logic                  out_load;
    logic                  in_xfer;

    skv_op_t               op;
    logic [KEY_BITS-1:0]   cmp_key;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;

    logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] cell_val   [TABLE_DEPTH];
    skv_flags_t            cell_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] dead_vec;
    logic [TABLE_DEPTH-1:0] slot_edge;
    logic [TABLE_DEPTH-1:0] live_edge;

    logic                  hit;
    logic [VALUE_BITS-1:0] hit_val;
    logic [CNT_W-1:0]      slot;
    logic [CNT_W-1:0]      slot_or;
    logic [CNT_W-1:0]      live_count;
    logic [CNT_W-1:0]      live_or;
    logic                  unsorted;
    logic                  full;

    assign cmp_key = (state_reg == ST_IDLE) ? key : nkey_hold_reg;
    assign wr_key  = (cmd_hold_reg == CMD_MAP) ? key_hold_reg : nkey_hold_reg;
    assign wr_val  = (cmd_hold_reg == CMD_MAP) ? val_hold_reg : res_val_reg;

    genvar j;
    generate
        for (j = 0; j < TABLE_DEPTH; j++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(j);
            localparam logic             ODD = (j % 2) == 1;
            logic [KEY_BITS-1:0]   l_key;
            logic [VALUE_BITS-1:0] l_val;
            skv_flags_t            l_flags;
            logic [KEY_BITS-1:0]   r_key;
            logic [VALUE_BITS-1:0] r_val;
            skv_flags_t            r_flags;

            if (j == 0)
            begin : g_head
                assign l_key   = '0;
                assign l_val   = '0;
                assign l_flags = '{lt: 1'b1, eq: 1'b0, dead: 1'b0};
            end
            else
            begin : g_mid_l
                assign l_key   = cell_key[j-1];
                assign l_val   = cell_val[j-1];
                assign l_flags = cell_flags[j-1];
            end

            if (j == TABLE_DEPTH - 1)
            begin : g_tail
                assign r_key   = cell_key[j];
                assign r_val   = cell_val[j];
                assign r_flags = '{lt: 1'b0, eq: 1'b0, dead: 1'b1};
            end
            else
            begin : g_mid_r
                assign r_key   = cell_key[j+1];
                assign r_val   = cell_val[j+1];
                assign r_flags = cell_flags[j+1];
            end

            skv_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .cmp_key     (cmp_key),
                .cmp_val     (value),
                .wr_key      (wr_key),
                .wr_val      (wr_val),
                .occ         (IDX < count_reg),
                .pair_right  (ODD == parity_reg),
                .left_key    (l_key),
                .left_val    (l_val),
                .left_flags  (l_flags),
                .right_key   (r_key),
                .right_val   (r_val),
                .right_flags (r_flags),
                .cell_key    (cell_key[j]),
                .cell_val    (cell_val[j]),
                .flags       (cell_flags[j])
            );

            assign lt_vec[j]   = cell_flags[j].lt;
            assign eq_vec[j]   = cell_flags[j].eq;
            assign dead_vec[j] = cell_flags[j].dead;
        end
    endgenerate

    assign slot_edge = ~lt_vec & {lt_vec[TABLE_DEPTH-2:0], 1'b1};
    assign live_edge = dead_vec & {~dead_vec[TABLE_DEPTH-2:0], 1'b1};
    assign unsorted  = |(dead_vec[TABLE_DEPTH-2:0] & ~dead_vec[TABLE_DEPTH-1:1]);
    assign hit       = |eq_vec;
    assign full      = (count_reg == DEPTH_CNT);

    always_comb
    begin
        slot_or = '0;
        live_or = '0;
        hit_val = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_edge[i])
            begin
                slot_or = slot_or | CNT_W'(i);
            end
            if (live_edge[i])
            begin
                live_or = live_or | CNT_W'(i);
            end
            if (eq_vec[i])
            begin
                hit_val = hit_val | cell_val[i];
            end
        end
        slot       = (|slot_edge) ? slot_or : DEPTH_CNT;
        live_count = (|live_edge) ? live_or : DEPTH_CNT;
    end

    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (command == CMD_UNMAP_VALUE)
                    begin
                        state_next = ST_COMPACT;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if ((cmd_hold_reg == CMD_REMAP) && (key_hold_reg != nkey_hold_reg))
                begin
                    state_next = ST_CMP2;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP2:
            begin
                state_next = ST_EVAL2;
            end
            ST_EVAL2:
            begin
                state_next = ST_DONE;
            end
            ST_COMPACT:
            begin
                if (!unsorted)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        op              = OP_NONE;
        count_next      = count_reg;
        parity_next     = parity_reg;
        hit_next        = hit_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_found_next  = 1'b0;
                    res_val_next    = '0;
                    res_pos_next    = DEPTH_CNT;
                    res_status_next = 1'b0;
                    parity_next     = 1'b0;
                    if (command == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (command == CMD_UNMAP_VALUE)
                    begin
                        op = OP_MARK;
                    end
                    else
                    begin
                        op = OP_COMPARE;
                    end
                end
            end
            ST_EVAL:
            begin
                hit_next       = hit;
                res_found_next = hit;
                res_val_next   = hit ? hit_val : '0;
                res_pos_next   = hit ? slot : DEPTH_CNT;
                case (cmd_hold_reg)
                    CMD_MAP:
                    begin
                        if (hit)
                        begin
                            op = OP_WRITE;
                        end
                        else if (full)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            op           = OP_INSERT;
                            count_next   = count_reg + ONE_CNT;
                            res_pos_next = slot;
                        end
                    end
                    CMD_UNMAP:
                    begin
                        if (hit)
                        begin
                            op         = OP_DELETE;
                            count_next = count_reg - ONE_CNT;
                        end
                    end
                    CMD_REMAP:
                    begin
                        if (hit && (key_hold_reg != nkey_hold_reg))
                        begin
                            op         = OP_DELETE;
                            count_next = count_reg - ONE_CNT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CMP2:
            begin
                op = OP_COMPARE;
            end
            ST_EVAL2:
            begin
                if (hit_reg)
                begin
                    if (hit)
                    begin
                        op = OP_WRITE;
                    end
                    else
                    begin
                        op         = OP_INSERT;
                        count_next = count_reg + ONE_CNT;
                    end
                end
                else if (hit)
                begin
                    op         = OP_DELETE;
                    count_next = count_reg - ONE_CNT;
                end
            end
            ST_COMPACT:
            begin
                if (unsorted)
                begin
                    op          = OP_SWAP;
                    parity_next = ~parity_reg;
                end
                else
                begin
                    count_next = live_count;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            parity_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            parity_reg    <= parity_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_hold_reg  <= command;
            key_hold_reg  <= key;
            nkey_hold_reg <= new_key;
            val_hold_reg  <= value;
        end
        res_found_reg  <= res_found_next;
        res_val_reg    <= res_val_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_val_reg    <= res_val_reg;
            out_pos_reg    <= res_pos_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign value_out   = out_val_reg;
    assign position    = out_pos_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

// ===== sv/skv_cell.sv =====
// ----------------------------------------------------------------------------
// skv_cell: one slot of the sorted table
// Holds one key/value pair and its lt, eq and dead flags; shifts data to or from
// its neighbors on insert, delete and compaction swaps.
// ----------------------------------------------------------------------------
module skv_cell
    import skv_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  skv_op_t               op,
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [VALUE_BITS-1:0] cmp_val,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic                  occ,
    input  logic                  pair_right,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_val,
    input  skv_flags_t            left_flags,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [VALUE_BITS-1:0] right_val,
    input  skv_flags_t            right_flags,
    output logic [KEY_BITS-1:0]   cell_key,
    output logic [VALUE_BITS-1:0] cell_val,
    output skv_flags_t            flags
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    skv_flags_t            flags_reg;
    skv_flags_t            flags_next;

    always_comb
    begin
        key_next   = key_reg;
        val_next   = val_reg;
        flags_next = flags_reg;
        case (op)
            OP_COMPARE:
            begin
                flags_next.lt = occ && (key_reg < cmp_key);
                flags_next.eq = occ && (key_reg == cmp_key);
            end
            OP_MARK:
            begin
                flags_next.dead = !occ || (val_reg == cmp_val);
            end
            OP_WRITE:
            begin
                if (flags_reg.eq)
                begin
                    val_next = wr_val;
                end
            end
            OP_INSERT:
            begin
                if (!flags_reg.lt)
                begin
                    if (left_flags.lt)
                    begin
                        key_next = wr_key;
                        val_next = wr_val;
                    end
                    else
                    begin
                        key_next = left_key;
                        val_next = left_val;
                    end
                end
            end
            OP_DELETE:
            begin
                if (!flags_reg.lt)
                begin
                    key_next = right_key;
                    val_next = right_val;
                end
            end
            OP_SWAP:
            begin
                if (pair_right)
                begin
                    if (flags_reg.dead && !right_flags.dead)
                    begin
                        key_next        = right_key;
                        val_next        = right_val;
                        flags_next.dead = 1'b0;
                    end
                end
                else
                begin
                    if (left_flags.dead && !flags_reg.dead)
                    begin
                        key_next        = left_key;
                        val_next        = left_val;
                        flags_next.dead = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign cell_key = key_reg;
    assign cell_val = val_reg;
    assign flags    = flags_reg;

endmodule
